FILE: rtl/core/sope_pkg.sv
// Shared types, constants and the per-spin factor lookup for the spin operator
// element generator. No dependencies.
`timescale 1ns / 1ps

package sope_pkg;

  localparam int IDX_W    = 16;  // row and column index width
  localparam int OUT_W    = 13;  // result value width
  localparam int SPIN_W   = 4;   // spin count register width
  localparam int OPS_W    = 24;  // packed op code register width
  localparam int OP_W     = 3;   // op code per spin
  localparam int SPIN_LIM = 8;   // most spins the op code register holds
  localparam int HIDX_W   = 8;   // Hilbert index width at SPIN_LIM spins
  localparam int CFG_W    = 2;   // configuration register index width

  localparam logic signed [OUT_W-1:0] OUT_MAX = 13'sd4095;
  localparam logic signed [OUT_W-1:0] OUT_MIN = -13'sd4095 - 13'sd1;

  // configuration register indexes
  localparam logic [CFG_W-1:0] CFG_SPIN_COUNT = 2'd0;
  localparam logic [CFG_W-1:0] CFG_OP_CODES   = 2'd1;
  localparam logic [CFG_W-1:0] CFG_COHERENT   = 2'd2;
  localparam logic [CFG_W-1:0] CFG_LIOUVILLE  = 2'd3;

  // per-spin operator codes; the two unused codes act as identity
  localparam logic [OP_W-1:0] OP_E  = 3'd0;
  localparam logic [OP_W-1:0] OP_LX = 3'd1;
  localparam logic [OP_W-1:0] OP_LY = 3'd2;
  localparam logic [OP_W-1:0] OP_LZ = 3'd3;
  localparam logic [OP_W-1:0] OP_LP = 3'd4;
  localparam logic [OP_W-1:0] OP_LM = 3'd5;

  typedef struct packed {
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] col_index;
  } req_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] real_part;
    logic signed [OUT_W-1:0] imag_part;
    logic                    out_of_range;
  } res_t;

  // active configuration, spin count already clamped
  typedef struct packed {
    logic [SPIN_W-1:0] n;
    logic [OPS_W-1:0]  ops;
    logic              coherent;
    logic              liouville;
  } cfg_t;

  // one 2x2 factor entry: nonzero flag, phase i^q, and a factor of one half
  typedef struct packed {
    logic       nz;
    logic [1:0] q;
    logic       half;
  } fac_t;

  function automatic fac_t factor(input logic [OP_W-1:0] op, input logic rb,
                                  input logic cb);
    fac_t f;
    f = '{nz: 1'b0, q: 2'd0, half: 1'b0};
    case (op)
      OP_LX: begin
        f.nz   = rb != cb;
        f.half = 1'b1;
      end
      OP_LY: begin
        f.nz   = rb != cb;
        f.half = 1'b1;
        f.q    = rb ? 2'd1 : 2'd3;
      end
      OP_LZ: begin
        f.nz   = rb == cb;
        f.half = 1'b1;
        f.q    = rb ? 2'd2 : 2'd0;
      end
      OP_LP: f.nz = !rb && cb;
      OP_LM: f.nz = rb && !cb;
      default: f.nz = rb == cb;
    endcase
    return f;
  endfunction

endpackage

FILE: rtl/core/spin_operator_element_generator.sv
// Spin operator element generator: returns one complex entry of a spin
// operator or its commutation superoperator per request.
// Depends on sope_pkg, sope_cfg and sope_hilbert.
//
// Usage:
//   Configuration: write spin_count, op_codes, coherent_mode and
//   liouville_space through cfg_valid_i / cfg_ready_o with cfg_index_i and
//   cfg_data_i, while no request is in flight. cfg_ready_o is always high.
//   Requests: drive req_i and raise start_i; a word is taken at each edge
//   where start_i is high and busy_o is low. busy_o never rises, so a new
//   request can be issued every cycle.
//   Results: res_o is valid for exactly one cycle with done_o high, after
//   the request passes the input register and then the result register.
//   Throughput is one entry per cycle; the entry is computed by one pass
//   through the per-spin factor logic between the two registers.
//   The receiver cannot stall; results are delivered in request order.
//   Reset clears the pipeline valids and restores the register defaults
//   (one spin, identity ops, sum mode, Hilbert space).
`timescale 1ns / 1ps

module spin_operator_element_generator #(
  parameter int MAX_SPINS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  sope_pkg::req_t             req_i,
  output logic                       done_o,
  output sope_pkg::res_t             res_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [sope_pkg::CFG_W-1:0] cfg_index_i,
  input  logic [sope_pkg::OPS_W-1:0] cfg_data_i
);

  localparam int NMAX = (MAX_SPINS < sope_pkg::SPIN_LIM) ? MAX_SPINS : sope_pkg::SPIN_LIM;
  localparam int SW   = MAX_SPINS + 6;
  localparam int CW   = (SW > sope_pkg::OUT_W + 1) ? SW : sope_pkg::OUT_W + 1;

  localparam logic signed [CW-1:0] SAT_HI = CW'(sope_pkg::OUT_MAX);
  localparam logic signed [CW-1:0] SAT_LO = CW'(sope_pkg::OUT_MIN);

  sope_pkg::cfg_t cfg;

  logic           valid_q;
  sope_pkg::req_t req_q;
  logic           done_q;
  sope_pkg::res_t res_d;
  sope_pkg::res_t res_q;

  logic [sope_pkg::HIDX_W-1:0] hmask;
  logic [sope_pkg::HIDX_W-1:0] r1, r2, c1, c2;
  logic                        oor;
  logic                        en_a, en_b;
  logic signed [SW-1:0]        re_a, im_a, re_b, im_b;
  logic signed [SW-1:0]        re_sum, im_sum;
  logic signed [CW-1:0]        re_w, im_w;

  sope_cfg #(
    .NMAX(NMAX)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      valid_q <= start_i;
      done_q  <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      req_q <= req_i;
    end
    if (valid_q) begin
      res_q <= res_d;
    end
  end

  // split indices into the Liouville halves; in Hilbert space r2/c2 equal
  // the in-range index itself
  always_comb begin
    hmask = sope_pkg::HIDX_W'((9'd1 << cfg.n) - 9'd1);
    r1    = sope_pkg::HIDX_W'(req_q.row_index >> cfg.n);
    c1    = sope_pkg::HIDX_W'(req_q.col_index >> cfg.n);
    r2    = req_q.row_index[sope_pkg::HIDX_W-1:0] & hmask;
    c2    = req_q.col_index[sope_pkg::HIDX_W-1:0] & hmask;
    if (cfg.liouville) begin
      oor = ((req_q.row_index >> {cfg.n, 1'b0}) != '0) ||
            ((req_q.col_index >> {cfg.n, 1'b0}) != '0);
    end else begin
      oor = ((req_q.row_index >> cfg.n) != '0) ||
            ((req_q.col_index >> cfg.n) != '0);
    end
    en_a = !cfg.liouville || (r1 == c1);
    en_b = cfg.liouville && (r2 == c2);
  end

  sope_hilbert #(
    .MAX_SPINS(MAX_SPINS),
    .SW       (SW)
  ) u_left (
    .cfg_i(cfg),
    .r_i  (r2),
    .c_i  (c2),
    .re_o (re_a),
    .im_o (im_a)
  );

  // transposed operator acting on the left factor
  sope_hilbert #(
    .MAX_SPINS(MAX_SPINS),
    .SW       (SW)
  ) u_right (
    .cfg_i(cfg),
    .r_i  (c1),
    .c_i  (r1),
    .re_o (re_b),
    .im_o (im_b)
  );

  always_comb begin
    re_sum = (en_a ? re_a : '0) - (en_b ? re_b : '0);
    im_sum = (en_a ? im_a : '0) - (en_b ? im_b : '0);
    re_w   = CW'(re_sum);
    im_w   = CW'(im_sum);
    res_d.out_of_range = oor;
    if (oor) begin
      res_d.real_part = '0;
      res_d.imag_part = '0;
    end else begin
      // saturate into the result range
      if (re_w > SAT_HI) begin
        res_d.real_part = sope_pkg::OUT_MAX;
      end else if (re_w < SAT_LO) begin
        res_d.real_part = sope_pkg::OUT_MIN;
      end else begin
        res_d.real_part = re_w[sope_pkg::OUT_W-1:0];
      end
      if (im_w > SAT_HI) begin
        res_d.imag_part = sope_pkg::OUT_MAX;
      end else if (im_w < SAT_LO) begin
        res_d.imag_part = sope_pkg::OUT_MIN;
      end else begin
        res_d.imag_part = im_w[sope_pkg::OUT_W-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

FILE: rtl/core/sope_cfg.sv
// Configuration register file with spin count clamping.
// Depends on sope_pkg.
`timescale 1ns / 1ps

module sope_cfg #(
  parameter int NMAX = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [sope_pkg::CFG_W-1:0] cfg_index_i,
  input  logic [sope_pkg::OPS_W-1:0] cfg_data_i,
  output sope_pkg::cfg_t             cfg_o
);

  logic [sope_pkg::SPIN_W-1:0] spin_count_q;
  logic [sope_pkg::OPS_W-1:0]  op_codes_q;
  logic                        coherent_q;
  logic                        liouville_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spin_count_q <= sope_pkg::SPIN_W'(1);
      op_codes_q   <= '0;
      coherent_q   <= 1'b0;
      liouville_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        sope_pkg::CFG_SPIN_COUNT: spin_count_q <= cfg_data_i[sope_pkg::SPIN_W-1:0];
        sope_pkg::CFG_OP_CODES:   op_codes_q   <= cfg_data_i;
        sope_pkg::CFG_COHERENT:   coherent_q   <= cfg_data_i[0];
        sope_pkg::CFG_LIOUVILLE:  liouville_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // clamp into 1..NMAX so every entry stays exact
  always_comb begin
    cfg_o.ops       = op_codes_q;
    cfg_o.coherent  = coherent_q;
    cfg_o.liouville = liouville_q;
    if (spin_count_q == '0) begin
      cfg_o.n = sope_pkg::SPIN_W'(1);
    end else if (spin_count_q > sope_pkg::SPIN_W'(NMAX)) begin
      cfg_o.n = sope_pkg::SPIN_W'(NMAX);
    end else begin
      cfg_o.n = spin_count_q;
    end
  end

endmodule

FILE: rtl/core/sope_hilbert.sv
// Hilbert-space entry A[r][c] of the configured operator, combinational.
// Depends on sope_pkg.
`timescale 1ns / 1ps

module sope_hilbert #(
  parameter int MAX_SPINS = 8,
  parameter int SW        = MAX_SPINS + 6
) (
  input  sope_pkg::cfg_t              cfg_i,
  input  logic [sope_pkg::HIDX_W-1:0] r_i,
  input  logic [sope_pkg::HIDX_W-1:0] c_i,
  output logic signed [SW-1:0]        re_o,
  output logic signed [SW-1:0]        im_o
);

  // one in fixed point
  localparam logic [SW-1:0] UNIT = {{(SW-MAX_SPINS-1){1'b0}}, 1'b1, {MAX_SPINS{1'b0}}};

  always_comb begin
    logic [2:0]                  pos;
    logic [sope_pkg::OP_W-1:0]   op;
    sope_pkg::fac_t              f;
    logic [1:0]                  qs;
    logic [3:0]                  hs;
    logic                        all_nz;
    logic [sope_pkg::HIDX_W-1:0] diff;
    logic [sope_pkg::HIDX_W-1:0] mask;
    logic signed [SW-1:0]        mag;
    logic signed [SW-1:0]        sre;
    logic signed [SW-1:0]        sim;
    pos    = '0;
    op     = '0;
    f      = '0;
    mask   = '0;
    mag    = '0;
    qs     = 2'd0;
    hs     = 4'd0;
    all_nz = 1'b1;
    sre    = '0;
    sim    = '0;
    diff   = r_i ^ c_i;
    for (int k = 0; k < sope_pkg::SPIN_LIM; k++) begin
      if (4'(k) < cfg_i.n) begin
        // spin 0 sits on the most significant index bit
        pos    = 3'(cfg_i.n - 4'(k) - 4'd1);
        op     = cfg_i.ops[sope_pkg::OP_W*k +: sope_pkg::OP_W];
        f      = sope_pkg::factor(op, r_i[pos], c_i[pos]);
        all_nz = all_nz & f.nz;
        qs     = qs + f.q;
        hs     = hs + {3'b000, f.half};
        mask   = sope_pkg::HIDX_W'(1) << pos;
        mag    = f.half ? signed'(UNIT >> 1) : signed'(UNIT);
        // a single-spin term is identity elsewhere: other bits must match
        if (op != sope_pkg::OP_E && op <= sope_pkg::OP_LM &&
            (diff & ~mask) == '0 && f.nz) begin
          case (f.q)
            2'd0:    sre = sre + mag;
            2'd1:    sim = sim + mag;
            2'd2:    sre = sre - mag;
            default: sim = sim - mag;
          endcase
        end
      end
    end
    if (cfg_i.coherent) begin
      re_o = '0;
      im_o = '0;
      mag  = signed'(UNIT >> hs);
      if (all_nz) begin
        case (qs)
          2'd0:    re_o = mag;
          2'd1:    im_o = mag;
          2'd2:    re_o = -mag;
          default: im_o = -mag;
        endcase
      end
    end else begin
      re_o = sre;
      im_o = sim;
    end
  end

endmodule
